@@ rtl/skac_pkg.sv @@
// Shared types, register codes and constants for the soft-knee compressor.
// No dependencies; imported by every module of the block.
package skac_pkg;

  localparam int CHANNELS      = 2;
  localparam int SAMPLE_BITS_D = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int M_W           = 32;   // linear gain mantissa, Q2.30
  localparam int SH_W          = 6;    // output shift amount

  localparam logic signed [23:0] DB_MIN = 24'sh800000;
  localparam logic signed [23:0] DB_MAX = 24'sh7FFFFF;
  localparam logic [19:0] DB_PER_LOG2_Q16 = 20'd394566;
  localparam logic [29:0] LOG2_PER_DB_Q32 = 30'd713378626;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_KNEE_HALF = 3'd1,
    REG_SLOPE     = 3'd2,
    REG_KNEE_CURV = 3'd3,
    REG_ATTACK    = 3'd4,
    REG_RELEASE   = 3'd5
  } skac_reg_t;

  typedef struct packed {
    logic idle;      // engine takes a new frame
    logic lane_mul;  // lanes form sample * gain
    logic finish;    // lane results are final
  } skac_status_t;

  // Taylor coefficients of 2^x, Horner order, Q2.30
  function automatic logic [M_W-1:0] exp2_coef(input logic [2:0] k);
    logic [M_W-1:0] c;
    case (k)
      3'd0:    c = 32'd165394;
      3'd1:    c = 32'd1431680;
      3'd2:    c = 32'd10327388;
      3'd3:    c = 32'd59597083;
      3'd4:    c = 32'd257941248;
      default: c = 32'd744261118;
    endcase
    return c;
  endfunction

  // saturate a Q8.16 value (already shifted) to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
    logic signed [23:0] r;
    if (v > 52'sd8388607)       r = DB_MAX;
    else if (v < -52'sd8388608) r = DB_MIN;
    else                        r = v[23:0];
    return r;
  endfunction

endpackage

@@ rtl/skac_lane.sv @@
// One channel lane: holds the sample, its magnitude, and scales it by the gain.
// Depends on skac_pkg.
module skac_lane import skac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          mul,
  input  logic [M_W-1:0]                m,
  input  logic [SH_W-1:0]               sh,
  output logic [SAMPLE_BITS-1:0]        mag,
  output logic [SAMPLE_BITS-1:0]        result
);

  localparam int P_W = SAMPLE_BITS + M_W + 1;

  logic                 neg;
  logic [P_W-1:0]       prod;
  logic [P_W-1:0]       rounded;
  logic [P_W-1:0]       shifted;
  logic [P_W-1:0]       lim;
  logic [SAMPLE_BITS-1:0] sat_mag;

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= sample[SAMPLE_BITS-1];
      mag <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    end
    if (mul) begin
      prod <= P_W'(mag) * P_W'(m);
    end
  end

  always_comb begin
    rounded = prod + (P_W'(1) << (sh - SH_W'(1)));
    shifted = rounded >> sh;
    lim     = (P_W'(1) << (SAMPLE_BITS - 1)) - (neg ? P_W'(0) : P_W'(1));
    sat_mag = (shifted > lim) ? lim[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
    result  = neg ? SAMPLE_BITS'(-sat_mag) : sat_mag;
  end

endmodule

@@ rtl/skac_merge.sv @@
// Merging stage: peak magnitude over all lanes.
// Depends on skac_pkg.
module skac_merge import skac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  logic [SAMPLE_BITS-1:0] mag [CHANNELS],
  output logic [SAMPLE_BITS-1:0] peak
);

  always_comb begin
    peak = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (mag[c] > peak) peak = mag[c];
    end
  end

endmodule

@@ rtl/skac_engine.sv @@
// Gain sequencer: level in dB, soft-knee curve, smoothers and exp2, on one
// shared multiplier. Holds the configuration registers. Depends on skac_pkg.
module skac_engine import skac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] peak,
  input  logic                   out_free,
  output skac_status_t           status,
  output logic [M_W-1:0]         m,
  output logic [SH_W-1:0]        sh
);

  localparam int L_W = 21;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PEAK, ST_NORM, ST_SQ, ST_DB1, ST_DB2, ST_CURVE, ST_KNEE,
    ST_REL1, ST_REL2, ST_ATT1, ST_ATT2, ST_EXP, ST_HORN, ST_LMUL, ST_DONE
  } state_t;

  state_t state;

  logic signed [23:0] threshold_db;
  logic        [22:0] knee_half_width;
  logic signed [16:0] gain_slope;
  logic signed [23:0] knee_curve_factor;
  logic        [15:0] attack_coeff;
  logic        [15:0] release_coeff;

  logic [SAMPLE_BITS-1:0] xn;
  logic [4:0]             p;
  logic [30:0]            x;
  logic [15:0]            frac;
  logic [3:0]             cnt;
  logic signed [23:0]     d;
  logic [32:0]            sqv;
  logic signed [23:0]     g;
  logic signed [23:0]     rel_gain;
  logic signed [23:0]     att_gain;
  logic signed [41:0]     acc;
  logic [15:0]            f;
  logic [2:0]             k;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [L_W-1:0]     lvl;
  logic [24:0]        q;
  logic signed [24:0] lo, hi, d_ext;
  logic signed [42:0] mix;
  logic signed [23:0] mixed;
  logic [30:0]        x_top;
  logic [31:0]        sqx;
  logic signed [21:0] e;
  logic signed [6:0]  sh_full;

  assign lvl   = (L_W'(SAMPLE_BITS - 1) << 16) - {p, frac};
  assign d_ext = 25'(d);
  assign lo    = 25'(threshold_db) - $signed({2'b00, knee_half_width});
  assign hi    = 25'(threshold_db) + $signed({2'b00, knee_half_width});
  assign x_top = 31'({xn, 31'b0} >> SAMPLE_BITS);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = 34'({3'b0, x});
        mul_b = 34'({3'b0, x});
      end
      ST_DB1, ST_DB2: begin
        mul_a = 34'({13'b0, lvl});
        mul_b = 34'({14'b0, DB_PER_LOG2_Q16});
      end
      ST_CURVE: begin
        if (d_ext > hi) begin
          mul_a = 34'(gain_slope);
          mul_b = 34'(d_ext - 25'(threshold_db));
        end else begin
          mul_a = 34'(d_ext - lo);
          mul_b = 34'(d_ext - lo);
        end
      end
      ST_KNEE: begin
        mul_a = 34'({1'b0, sqv});
        mul_b = 34'(knee_curve_factor);
      end
      ST_REL1: begin
        mul_a = 34'({18'b0, release_coeff});
        mul_b = 34'(rel_gain);
      end
      ST_REL2: begin
        mul_a = 34'(18'h10000 - {2'b0, release_coeff});
        mul_b = 34'(g);
      end
      ST_ATT1: begin
        mul_a = 34'({18'b0, attack_coeff});
        mul_b = 34'(att_gain);
      end
      ST_ATT2: begin
        mul_a = 34'(18'h10000 - {2'b0, attack_coeff});
        mul_b = 34'(rel_gain);
      end
      ST_EXP: begin
        mul_a = 34'(att_gain);
        mul_b = 34'({4'b0, LOG2_PER_DB_Q32});
      end
      ST_HORN: begin
        mul_a = 34'({2'b0, m});
        mul_b = 34'({18'b0, f});
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign sqx     = prod[61:30];
  assign q       = 25'((prod[40:0] + 41'd32768) >> 16);
  assign mix     = 43'(acc) + 43'(prod[41:0]);
  assign mixed   = mix[39:16];
  assign e       = prod[53:32];
  assign sh_full = 7'sd30 - 7'(e[21:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      threshold_db      <= -24'sd294912;
      knee_half_width   <= 23'd13107;
      gain_slope        <= -17'sd36409;
      knee_curve_factor <= -24'sd45511;
      attack_coeff      <= 16'd64553;
      release_coeff     <= 16'd64879;
      rel_gain          <= '0;
      att_gain          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold_db      <= cfg_data[23:0];
          REG_KNEE_HALF: knee_half_width   <= cfg_data[22:0];
          REG_SLOPE:     gain_slope        <= cfg_data[16:0];
          REG_KNEE_CURV: knee_curve_factor <= cfg_data[23:0];
          REG_ATTACK:    attack_coeff      <= cfg_data[15:0];
          REG_RELEASE:   release_coeff     <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (start) state <= ST_PEAK;
        ST_PEAK: begin
          if (peak == '0) begin
            d     <= DB_MIN;
            state <= ST_CURVE;
          end else begin
            xn    <= peak;
            p     <= 5'(SAMPLE_BITS - 1);
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (xn[SAMPLE_BITS-1]) begin
            x     <= x_top;
            frac  <= '0;
            cnt   <= '0;
            state <= ST_SQ;
          end else begin
            xn <= xn << 1;
            p  <= p - 5'd1;
          end
        end
        ST_SQ: begin
          x    <= sqx[31] ? sqx[31:1] : sqx[30:0];
          frac <= {frac[14:0], sqx[31]};
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) state <= ST_DB1;
        end
        ST_DB1: state <= ST_DB2;
        ST_DB2: begin
          d     <= (q > 25'd8388608) ? DB_MIN : 24'(25'd0 - q);
          state <= ST_CURVE;
        end
        ST_CURVE: begin
          if (d_ext < lo) begin
            g     <= '0;
            state <= ST_REL1;
          end else if (d_ext > hi) begin
            g     <= sat24(prod[67:16]);
            state <= ST_REL1;
          end else begin
            sqv   <= prod[48:16];
            state <= ST_KNEE;
          end
        end
        ST_KNEE: begin
          g     <= sat24(prod[67:16]);
          state <= ST_REL1;
        end
        ST_REL1: begin
          acc   <= prod[41:0];
          state <= ST_REL2;
        end
        ST_REL2: begin
          rel_gain <= (g < mixed) ? g : mixed;
          state    <= ST_ATT1;
        end
        ST_ATT1: begin
          acc   <= prod[41:0];
          state <= ST_ATT2;
        end
        ST_ATT2: begin
          att_gain <= mixed;
          state    <= ST_EXP;
        end
        ST_EXP: begin
          f     <= e[15:0];
          sh    <= sh_full[SH_W-1:0];
          m     <= exp2_coef(3'd0);
          k     <= 3'd1;
          state <= ST_HORN;
        end
        ST_HORN: begin
          if (k == 3'd6) begin
            m     <= 32'h4000_0000 + prod[47:16];
            state <= ST_LMUL;
          end else begin
            m <= exp2_coef(k) + prod[47:16];
            k <= k + 3'd1;
          end
        end
        ST_LMUL: state <= ST_DONE;
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign status.idle     = (state == ST_IDLE);
  assign status.lane_mul = (state == ST_LMUL);
  assign status.finish   = (state == ST_DONE);

  a_norm_sq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> x[30]) else $error("squaring operand lost normalization");
  a_rel_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REL2) |=> (rel_gain <= g)) else $error("release gain above curve gain");
  a_horn_k: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HORN) |-> (k >= 3'd1 && k <= 3'd6)) else $error("Horner step out of range");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_PEAK)) else $error("frame start missed");

endmodule

@@ rtl/soft_knee_audio_compressor_core.sv @@
// Soft-knee feed-forward compressor, one stereo frame per beat.
// The input stalls until the gain sequencer is idle again; no frame is taken
// while the last is in work. The shared gain multiplier and its 16-step log2
// squaring loop set that pace. A silent frame skips normalization and the
// loop; a knee frame also passes the knee state. The output register lets
// the next frame start while a result waits. Reset (rst, synchronous) restores
// the default coefficients and clears both smoother states and output valid.
module soft_knee_audio_compressor_core import skac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_left,
  input  logic signed [SAMPLE_BITS-1:0] sample_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  skac_status_t           status;
  logic                   accept;
  logic                   out_free;
  logic [M_W-1:0]         m;
  logic [SH_W-1:0]        sh;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] mag    [CHANNELS];
  logic [SAMPLE_BITS-1:0] result [CHANNELS];
  logic [SAMPLE_BITS-1:0] sample [CHANNELS];

  // new beat only when the sequencer is idle
  assign in_stall = !status.idle;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign sample[0] = sample_left;
  assign sample[1] = sample_right;

  // one lane per channel: magnitude on load, scaling at the end
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    skac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk    (clk),
      .load   (accept),
      .sample (sample[c]),
      .mul    (status.lane_mul),
      .m      (m),
      .sh     (sh),
      .mag    (mag[c]),
      .result (result[c])
    );
  end

  skac_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .mag  (mag),
    .peak (peak)
  );

  skac_engine #(.SAMPLE_BITS(SAMPLE_BITS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (accept),
    .peak      (peak),
    .out_free  (out_free),
    .status    (status),
    .m         (m),
    .sh        (sh)
  );

  // output register: loaded when the frame finishes and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.finish && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.finish && out_free) begin
      out_left  <= result[0];
      out_right <= result[1];
    end
  end

endmodule
